[hdl/iirl_pkg.sv]
// Package for the indexed insert/remove list.
// Holds request and status codes and the per-cell control struct.
// No dependencies.
`default_nettype none

package iirl_pkg;

  // Request codes; codes 6 and 7 are unused and get a bounds status
  typedef enum logic [2:0] {
    OP_READ   = 3'd0,
    OP_WRITE  = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_APPEND = 3'd4,
    OP_POP    = 3'd5
  } op_e;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  // What every cell in the row does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_REMOVE = 2'd3
  } cell_cmd_e;

  // Broadcast command plus the cell's own position relative to the target
  typedef struct packed {
    cell_cmd_e cmd;
    logic      hit;    // cell index equals the target index
    logic      above;  // cell index is above the target index
  } cell_ctrl_t;

  localparam int unsigned OpW     = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;

endpackage

`default_nettype wire

[hdl/iirl_if.sv]
// Request and response channel interfaces for the indexed insert/remove list.
// Valid/ready handshake; depends on iirl_pkg for field widths.
`default_nettype none

interface iirl_req_if;
  logic                                  valid;
  logic                                  ready;
  logic        [iirl_pkg::OpW-1:0]       operation;
  logic        [iirl_pkg::PosW-1:0]      position;
  logic signed [iirl_pkg::ValW-1:0]      value;

  modport source (output valid, output operation, output position, output value,
                  input ready);
  modport sink   (input valid, input operation, input position, input value,
                  output ready);
endinterface

interface iirl_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [iirl_pkg::ValW-1:0]      read_value;
  logic        [iirl_pkg::PosW-1:0]      entry_count;
  logic        [iirl_pkg::StatusW-1:0]   status;

  modport source (output valid, output read_value, output entry_count, output status,
                  input ready);
  modport sink   (input valid, input read_value, input entry_count, input status,
                  output ready);
endinterface

`default_nettype wire

[hdl/indexed_insert_remove_list.sv]
// Indexed insert/remove list: an ordered row of DEPTH cells with an entry count.
// The response is registered: response valid rises in the cycle after accept.
// Throughput: 1 request per cycle while the response register is free or
// drains; any shift of the cells at and above the target is done at once.
// Reset: clears the entry count and the response valid; cell contents stay
// undefined until written and are never read before that. No clearing pass.
`default_nettype none

module indexed_insert_remove_list #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 32
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  iirl_req_if.sink   req_i,
  iirl_rsp_if.source rsp_o
);
  import iirl_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]      count_d, count_q;
  logic [WIDTH-1:0]     cell_q [DEPTH];
  logic [WIDTH-1:0]     din;
  cell_ctrl_t           cell_ctrl [DEPTH];

  logic                 accept;
  cell_cmd_e            cmd;
  logic [CntW-1:0]      tgt;
  logic [IdxW-1:0]      rd_idx;
  logic                 rd_en;
  status_e              st;
  logic [CntW-1:0]      cnt_nxt;
  logic [31:0]          pos_w, cnt_w;
  logic                 full;
  logic [WIDTH-1:0]     rd_word;

  logic                 rsp_valid_q;
  logic [ValW-1:0]      rsp_value_q;
  logic [PosW-1:0]      rsp_count_q;
  status_e              rsp_status_q;

  // Handshake: take a request whenever the response register is free or drains
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  // Request value in its low WIDTH bits
  assign din = WIDTH'($unsigned(req_i.value));

  // Decode the request against the current count
  always_comb begin
    pos_w   = 32'(req_i.position);
    cnt_w   = 32'(count_q);
    full    = (count_q == CntW'(DEPTH));
    cmd     = CMD_HOLD;
    tgt     = CntW'(req_i.position);
    rd_idx  = IdxW'(req_i.position);
    rd_en   = 1'b0;
    st      = ST_OK;
    cnt_nxt = count_q;
    case (op_e'(req_i.operation))
      OP_READ: begin
        if (pos_w < cnt_w) rd_en = 1'b1;
        else st = ST_BOUNDS;
      end
      OP_WRITE: begin
        if (pos_w < cnt_w) cmd = CMD_WRITE;
        else st = ST_BOUNDS;
      end
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          st = ST_BOUNDS;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          cmd     = CMD_INSERT;
          cnt_nxt = count_q + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (pos_w < cnt_w) begin
          cmd     = CMD_REMOVE;
          rd_en   = 1'b1;
          cnt_nxt = count_q - 1'b1;
        end else begin
          st = ST_BOUNDS;
        end
      end
      OP_APPEND: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          cmd     = CMD_WRITE;
          tgt     = count_q;
          cnt_nxt = count_q + 1'b1;
        end
      end
      OP_POP: begin
        // Last entry leaves; nothing moves, only the count drops
        if (count_q == '0) begin
          st = ST_BOUNDS;
        end else begin
          rd_en   = 1'b1;
          rd_idx  = IdxW'(count_q - 1'b1);
          cnt_nxt = count_q - 1'b1;
        end
      end
      default: st = ST_BOUNDS;
    endcase
  end

  assign count_d = accept ? cnt_nxt : count_q;

  // Read select from the row
  assign rd_word = rd_en ? cell_q[rd_idx] : '0;

  // Row of cells, each told where it sits relative to the target
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] lower, upper;

    if (i == 0) begin : g_first
      assign lower = '0;
    end else begin : g_lower
      assign lower = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign upper = '0;
    end else begin : g_upper
      assign upper = cell_q[i+1];
    end

    always_comb begin
      cell_ctrl[i].cmd   = accept ? cmd : CMD_HOLD;
      cell_ctrl[i].hit   = (tgt == CntW'(i));
      cell_ctrl[i].above = (tgt < CntW'(i));
    end

    iirl_cell #(
      .WIDTH(WIDTH)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .din_i  (din),
      .lower_i(lower),
      .upper_i(upper),
      .q_o    (cell_q[i])
    );
  end

  // Entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (accept) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  // Response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_value_q  <= ValW'(rd_word);
      rsp_count_q  <= PosW'(cnt_nxt);
      rsp_status_q <= st;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.read_value  = $signed(rsp_value_q);
  assign rsp_o.entry_count = rsp_count_q;
  assign rsp_o.status      = rsp_status_q;

  // Count never runs past the row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= DEPTH)
    else $error("entry count beyond depth");

  // A full status only when the row was full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && st == ST_FULL) |-> full)
    else $error("full status with free cells");

  // A granted insert grows the count by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && cmd == CMD_INSERT) |=> (count_q == $past(count_q) + 1'b1))
    else $error("insert did not grow the count");

  // Reads and writes leave the count alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.operation == OP_READ || req_i.operation == OP_WRITE))
      |=> $stable(count_q))
    else $error("read or write changed the count");

  // Reported count matches the count register after each request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (rsp_count_q == PosW'(count_q)))
    else $error("response count out of step");

endmodule

`default_nettype wire

[hdl/iirl_cell.sv]
// One storage cell of the list row: holds a single entry and can load the
// request value or take the word of its lower or upper neighbor. Uses iirl_pkg.
`default_nettype none

module iirl_cell #(
  parameter int unsigned WIDTH = 32
) (
  input  wire                         clk_i,
  input  iirl_pkg::cell_ctrl_t        ctrl_i,
  input  wire         [WIDTH-1:0]     din_i,
  input  wire         [WIDTH-1:0]     lower_i,
  input  wire         [WIDTH-1:0]     upper_i,
  output logic        [WIDTH-1:0]     q_o
);
  import iirl_pkg::*;

  logic [WIDTH-1:0] data_d, data_q;

  // Next entry: load, shift up from below, shift down from above, or keep
  always_comb begin
    data_d = data_q;
    case (ctrl_i.cmd)
      CMD_WRITE: begin
        if (ctrl_i.hit) data_d = din_i;
      end
      CMD_INSERT: begin
        if (ctrl_i.hit) begin
          data_d = din_i;
        end else if (ctrl_i.above) begin
          data_d = lower_i;
        end
      end
      CMD_REMOVE: begin
        if (ctrl_i.hit || ctrl_i.above) data_d = upper_i;
      end
      default: data_d = data_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign q_o = data_q;

endmodule

`default_nettype wire
